// ===== sv/rescaled_range_abs_returns_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rescaled-range block
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESCALED_RANGE_ABS_RETURNS_ASSERT_SVH
`define RESCALED_RANGE_ABS_RETURNS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// cond must never hold
`define RRA_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rra check failed");
// a implies b in the same cycle
`define RRA_ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rra check failed");
// a implies b in the next cycle
`define RRA_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("rra check failed");
`else
`define RRA_ASSERT_NEVER(label, cond)
`define RRA_ASSERT_IMPLY(label, a, b)
`define RRA_ASSERT_NEXT(label, a, b)
`endif

`endif

// ===== sv/rra_pkg.sv =====
// ----------------------------------------------------------------------------
// rra_pkg
// Shared types and fixed widths of the rescaled-range block.
// ----------------------------------------------------------------------------
package rra_pkg;

  localparam int PRICE_W = 32;
  localparam int RES_W   = 32;
  localparam int WIN_W   = 9;
  localparam int SEEN_W  = 10;
  localparam int FRAC_W  = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = 9'd300;
  localparam logic [RES_W-1:0] RES_SAT   = 32'hFFFF_FFFF;

  // core status towards the top level
  typedef struct packed {
    logic busy;
    logic res_valid;
  } core_stat_t;

endpackage

// ===== sv/rra_ring.sv =====
// ----------------------------------------------------------------------------
// rra_ring
// Ring store of absolute price changes: one write port, one registered read.
// ----------------------------------------------------------------------------
module rra_ring #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [rra_pkg::PRICE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [rra_pkg::PRICE_W-1:0] rdata
);

  logic [rra_pkg::PRICE_W-1:0] mem [DEPTH];
  logic [rra_pkg::PRICE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rra_core.sv =====
// ----------------------------------------------------------------------------
// rra_core
// Sequencer over two ring passes, shift-add products, square root, divide.
// ----------------------------------------------------------------------------
module rra_core #(
  parameter int MAX_RETURNS = 512,
  parameter int AW          = 9,
  parameter int NW          = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [NW-1:0]               n_in,
  input  logic [AW-1:0]               start_in,
  output logic [AW-1:0]               rd_addr,
  input  logic [rra_pkg::PRICE_W-1:0] rd_data,
  input  logic                        take,
  output rra_pkg::core_stat_t         stat,
  output logic [rra_pkg::RES_W-1:0]   result
);

  localparam int PW   = rra_pkg::PRICE_W;
  localparam int TW   = PW + NW;            // sum of changes
  localparam int QW   = 2 * PW + NW;        // sum of squares
  localparam int VW   = QW + NW;            // n*Q - T*T
  localparam int RTW  = VW / 2;             // root
  localparam int RMS  = RTW + 3;            // root remainder
  localparam int YW   = TW + NW + 2;        // running deviation sum
  localparam int MW   = PW + NW;            // n*r
  localparam int NUMW = YW + rra_pkg::FRAC_W;
  localparam int KW   = $clog2(TW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;
  localparam logic [3:0] S_P2   = 4'd2;
  localparam logic [3:0] S_MNQ  = 4'd3;
  localparam logic [3:0] S_MTT  = 4'd4;
  localparam logic [3:0] S_ZCHK = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DCHK = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]           state_r;
  logic [NW-1:0]        n_r, iss_r;
  logic [AW-1:0]        base_r, addr_r, addr_inc;
  logic                 v1_r, v2_r, first_r;
  logic [TW-1:0]        t_r, mb_r;
  logic [QW-1:0]        q_r;
  logic [2*PW-1:0]      sq_r;
  logic [PW-1:0]        dat_r;
  logic [MW-1:0]        prod_r;
  logic signed [YW-1:0] y_r, ymin_r, ymax_r, y_nxt;
  logic [VW-1:0]        acc_r, mx_r, rad_r, add_b, acc_sum;
  logic [KW-1:0]        cnt_r;
  logic [RTW-1:0]       root_r, drem_r, drem_nxt;
  logic [RMS-1:0]       rem_r, rem_sh, trial;
  logic [NUMW-1:0]      num_r;
  logic [RTW:0]         rt;
  logic                 qb, rge, sat;
  logic [rra_pkg::RES_W-1:0] dq_r, res_r;
  logic                 issuing, pass_end, in_pass;
  logic [YW-1:0]        rn;

  assign in_pass  = (state_r == S_P1) || (state_r == S_P2);
  assign issuing  = in_pass && (iss_r != n_r);
  assign pass_end = in_pass && (iss_r == n_r) && !v1_r && !v2_r;
  assign addr_inc = (addr_r == AW'(MAX_RETURNS - 1)) ? '0 : addr_r + 1'b1;
  assign rd_addr  = addr_r;

  assign y_nxt = y_r + $signed(YW'(prod_r)) - $signed(YW'(t_r));
  assign rn    = YW'(ymax_r - ymin_r);

  // shared adder for both shift-add products
  assign add_b   = mb_r[0] ? mx_r : '0;
  assign acc_sum = (state_r == S_MTT) ? acc_r - add_b : acc_r + add_b;

  // one root digit per step
  assign rem_sh = {rem_r[RMS-3:0], rad_r[VW-1:VW-2]};
  assign trial  = RMS'({root_r, 2'b01});
  assign rge    = rem_sh >= trial;

  // one quotient bit per step
  assign rt       = {drem_r, num_r[31]};
  assign qb       = rt >= {1'b0, root_r};
  assign drem_nxt = qb ? RTW'(rt - {1'b0, root_r}) : RTW'(rt);

  // quotient of 2^32 or more
  assign sat = {{YW{1'b0}}, root_r, {rra_pkg::FRAC_W{1'b0}}} <=
               {{(RTW + rra_pkg::FRAC_W){1'b0}}, num_r[NUMW-1:rra_pkg::FRAC_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      v1_r <= issuing;
      v2_r <= v1_r;
      if (issuing) begin
        addr_r <= addr_inc;
        iss_r  <= iss_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            n_r     <= n_in;
            base_r  <= start_in;
            addr_r  <= start_in;
            iss_r   <= '0;
            t_r     <= '0;
            q_r     <= '0;
            state_r <= S_P1;
          end
        end
        S_P1: begin
          if (v1_r) begin
            sq_r  <= rd_data * rd_data;
            dat_r <= rd_data;
          end
          if (v2_r) begin
            t_r <= t_r + TW'(dat_r);
            q_r <= q_r + QW'(sq_r);
          end
          if (pass_end) begin
            addr_r  <= base_r;
            iss_r   <= '0;
            first_r <= 1'b1;
            y_r     <= '0;
            state_r <= S_P2;
          end
        end
        S_P2: begin
          if (v1_r) begin
            prod_r <= MW'(rd_data) * MW'(n_r);
          end
          if (v2_r) begin
            y_r     <= y_nxt;
            first_r <= 1'b0;
            if (first_r || (y_nxt < ymin_r)) ymin_r <= y_nxt;
            if (first_r || (y_nxt > ymax_r)) ymax_r <= y_nxt;
          end
          if (pass_end) begin
            num_r   <= {rn, {rra_pkg::FRAC_W{1'b0}}};
            acc_r   <= '0;
            mx_r    <= VW'(q_r);
            mb_r    <= TW'(n_r);
            cnt_r   <= KW'(NW);
            state_r <= S_MNQ;
          end
        end
        S_MNQ, S_MTT: begin
          acc_r <= acc_sum;
          if (cnt_r == KW'(1)) begin
            if (state_r == S_MNQ) begin
              mx_r    <= VW'(t_r);
              mb_r    <= t_r;
              cnt_r   <= KW'(TW);
              state_r <= S_MTT;
            end else begin
              state_r <= S_ZCHK;
            end
          end else begin
            mx_r  <= mx_r << 1;
            mb_r  <= mb_r >> 1;
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_ZCHK: begin
          if (acc_r == '0) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else begin
            rad_r   <= acc_r;
            root_r  <= '0;
            rem_r   <= '0;
            cnt_r   <= KW'(RTW);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad_r  <= rad_r << 2;
          rem_r  <= rge ? rem_sh - trial : rem_sh;
          root_r <= {root_r[RTW-2:0], rge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == KW'(1)) state_r <= S_DCHK;
        end
        S_DCHK: begin
          if (sat) begin
            res_r   <= rra_pkg::RES_SAT;
            state_r <= S_DONE;
          end else begin
            drem_r  <= RTW'(num_r >> 32);
            cnt_r   <= KW'(32);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          drem_r <= drem_nxt;
          num_r  <= num_r << 1;
          dq_r   <= {dq_r[30:0], qb};
          res_r  <= {dq_r[30:0], qb};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == KW'(1)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (take) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.busy      = (state_r != S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign result         = res_r;

endmodule

// ===== sv/rescaled_range_abs_returns.sv =====
// ----------------------------------------------------------------------------
// rescaled_range_abs_returns
// R/S statistic of the newest n absolute price changes, Q16.16 result.
// ----------------------------------------------------------------------------
// Flow: a price that yields a result starts two ring passes, one memory
//   read each per change, then the shift-add products, root and divide.
//   Zero deviation skips the root and divide; saturation skips the divide.
// No new price is taken while the core is busy; a price with no result
//   leaves the core idle.
// Reset: synchronous on rst_n low; window 300, counters and last price clear.
// ----------------------------------------------------------------------------
`include "rescaled_range_abs_returns_assert.svh"

module rescaled_range_abs_returns #(
  parameter int MAX_RETURNS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // price requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] close_price
  // result requests
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] rs_ratio
  // window register
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata   // window_length
);

  localparam int AW = $clog2(MAX_RETURNS);
  localparam int NW = $clog2(MAX_RETURNS + 1);
  localparam int CW = (NW > rra_pkg::SEEN_W) ? NW : rra_pkg::SEEN_W;
  localparam int EW = NW + 1;

  logic [rra_pkg::WIN_W-1:0]   win_r;
  logic [rra_pkg::PRICE_W-1:0] prev_r, absret;
  logic [AW-1:0]               wp_r, wp_inc, wp_after, start_addr, rd_addr;
  logic [rra_pkg::SEEN_W-1:0]  seen_r, seen_nxt, need, n_full;
  logic [NW-1:0]               n_win;
  logic [EW-1:0]               st_wide;
  logic                        accept, have_prev, go, take;
  logic [rra_pkg::PRICE_W-1:0] rd_data;
  logic [rra_pkg::RES_W-1:0]   core_res, out_r;
  logic                        out_valid_r;
  rra_pkg::core_stat_t         stat;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !stat.busy;
  assign have_prev = (seen_r != '0);

  // absolute change against the previous close
  assign absret = (in_tdata >= prev_r) ? in_tdata - prev_r : prev_r - in_tdata;

  assign wp_inc   = (wp_r == AW'(MAX_RETURNS - 1)) ? '0 : wp_r + 1'b1;
  assign wp_after = have_prev ? wp_inc : wp_r;

  // count stops at W+3 but never drops when the window shrinks
  assign need     = {1'b0, win_r} + rra_pkg::SEEN_W'(3);
  assign seen_nxt = (seen_r < need) ? seen_r + 1'b1 : seen_r;
  assign go       = accept && (seen_nxt >= need);

  // n = W+1 capped at ring depth
  assign n_full = {1'b0, win_r} + 1'b1;
  assign n_win  = (CW'(n_full) > CW'(MAX_RETURNS)) ? NW'(MAX_RETURNS) : NW'(n_full);

  // oldest change of the window
  assign st_wide = (EW'(wp_after) >= EW'(n_win)) ?
                   EW'(wp_after) - EW'(n_win) :
                   EW'(wp_after) + EW'(MAX_RETURNS) - EW'(n_win);
  assign start_addr = AW'(st_wide);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= rra_pkg::WIN_RESET;
      prev_r <= '0;
      wp_r   <= '0;
      seen_r <= '0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      if (accept) begin
        prev_r <= in_tdata;
        wp_r   <= wp_after;
        seen_r <= seen_nxt;
      end
    end
  end

  rra_ring #(
    .DEPTH (MAX_RETURNS),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (accept && have_prev),
    .waddr (wp_r),
    .wdata (absret),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rra_core #(
    .MAX_RETURNS (MAX_RETURNS),
    .AW          (AW),
    .NW          (NW)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .n_in     (n_win),
    .start_in (start_addr),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .take     (take),
    .stat     (stat),
    .result   (core_res)
  );

  // output register frees the core while the result waits
  assign take = stat.res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_r <= core_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  `RRA_ASSERT_IMPLY(a_go_idle, go, !stat.busy)
  `RRA_ASSERT_NEXT(a_go_busy, go, stat.busy)
  `RRA_ASSERT_NEXT(a_take_shows, take, out_valid_r && (out_r == $past(core_res)))
  `RRA_ASSERT_NEVER(a_seen_cap, seen_r > rra_pkg::SEEN_W'(514))

endmodule

// ===== test/rescaled_range_abs_returns_check.sv =====
// ----------------------------------------------------------------------------
// rescaled_range_abs_returns_check
// Watches the price, result and window ports, predicts each R/S value
// from its own copy of the state and compares results in order.
// ----------------------------------------------------------------------------
module rescaled_range_abs_returns_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  output int          fail_count,
  output int          ratios_pending
);

  localparam int RING_DEPTH = 512;

  logic [rra_pkg::PRICE_W-1:0] last_close;
  logic [31:0]                 change_ring [RING_DEPTH];
  int unsigned                 ring_wr;
  int unsigned                 closes_seen;
  logic [rra_pkg::WIN_W-1:0]   window;
  logic [rra_pkg::RES_W-1:0]   ratio_q [$];

  assign ratios_pending = ratio_q.size();

  // R/S of the newest n changes, Q16.16, saturating
  function automatic logic [rra_pkg::RES_W-1:0] rs_ratio_of(int unsigned n);
    int unsigned  first;
    logic [63:0]  tot;
    logic [127:0] sq_sum, var_n, cand2, quo;
    longint       run, run_min, run_max;
    logic [63:0]  range_n, root, cand;
    tot = 0;
    sq_sum = 0;
    run = 0;
    run_min = 0;
    run_max = 0;
    root = 0;
    first = (ring_wr + RING_DEPTH - n) % RING_DEPTH;
    for (int k = 0; k < n; k++) begin
      tot += 64'(change_ring[(first + k) % RING_DEPTH]);
      sq_sum += 128'(change_ring[(first + k) % RING_DEPTH]) *
                128'(change_ring[(first + k) % RING_DEPTH]);
    end
    for (int k = 0; k < n; k++) begin
      run += longint'(64'(change_ring[(first + k) % RING_DEPTH]) * 64'(n)) - longint'(tot);
      if (k == 0 || run < run_min) run_min = run;
      if (k == 0 || run > run_max) run_max = run;
    end
    range_n = 64'(run_max - run_min);
    var_n = sq_sum * 128'(n) - 128'(tot) * 128'(tot);
    if (var_n == 0) return '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      cand2 = 128'(cand) * 128'(cand);
      if (cand2 <= var_n) root = cand;
    end
    quo = (128'(range_n) << rra_pkg::FRAC_W) / 128'(root);
    if (quo > 128'(rra_pkg::RES_SAT)) return rra_pkg::RES_SAT;
    return quo[rra_pkg::RES_W-1:0];
  endfunction

  always @(posedge clk) begin
    int unsigned need, n;
    logic [31:0] chg;
    logic [rra_pkg::RES_W-1:0] want;
    if (!rst_n) begin
      last_close  <= '0;
      ring_wr     = 0;
      closes_seen = 0;
      window      <= rra_pkg::WIN_RESET;
      fail_count  = 0;
      ratio_q.delete();
    end else begin
      // price request: update state and predict
      if (in_tvalid && in_tready) begin
        need = int'(window) + 3;
        if (closes_seen >= 1) begin
          chg = (in_tdata >= last_close) ? in_tdata - last_close : last_close - in_tdata;
          change_ring[ring_wr] = chg;
          ring_wr = (ring_wr + 1) % RING_DEPTH;
        end
        last_close <= in_tdata;
        if (closes_seen < need) closes_seen++;
        if (closes_seen >= need) begin
          n = int'(window) + 1;
          if (n > RING_DEPTH) n = RING_DEPTH;
          ratio_q.push_back(rs_ratio_of(n));
        end
      end
      // result request: compare with oldest prediction
      if (out_tvalid && out_tready) begin
        if (ratio_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result rs_ratio=%h", out_tdata);
        end else begin
          want = ratio_q.pop_front();
          if (want !== out_tdata) begin
            fail_count++;
            if (fail_count <= 10)
              $display("rs_ratio mismatch: expected %h actual %h", want, out_tdata);
          end
        end
      end
      if (cfg_we) window <= cfg_wdata;
    end
  end

endmodule

// ===== test/rescaled_range_abs_returns_test.sv =====
// ----------------------------------------------------------------------------
// rescaled_range_abs_returns_test
// Drives prices through several window settings with random gaps on both
// sides and one long result stall; a checker predicts and compares.
// ----------------------------------------------------------------------------
module rescaled_range_abs_returns_test;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] close_price
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] rs_ratio
  logic        cfg_we;
  logic [8:0]  cfg_wdata;   // window_length

  int  fail_count;
  int  ratios_pending;
  bit  gaps_on;             // random idling on both sides when set
  bit  hold_results;        // one long receiver stall when set
  logic [31:0] last_px;
  logic [31:0] px_step;

  rescaled_range_abs_returns DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  rescaled_range_abs_returns_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .ratios_pending (ratios_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("rescaled_range_abs_returns test failed");
    $finish;
  end

  // result side: random stalls, one long hold-off while prices keep coming
  initial begin
    bit hs;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (4000) @(posedge clk);
        hold_results = 1'b0;
      end else if (gaps_on) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        hs = out_tvalid;
        @(posedge clk);
      end while (!hs);
    end
  end

  // one price request; gap drawn per request, tvalid only dropped on a gap
  task automatic send_close(input logic [31:0] px);
    int  gap;
    bit  hs;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do begin
      @(negedge clk);
      hs = in_tready;
      @(posedge clk);
    end while (!hs);
    last_px = px;
  endtask

  // window write only once the block has drained
  task automatic set_window(input logic [8:0] w);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ratios_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random close: mostly walks and even steps, some constant runs and noise
  task automatic send_random(input int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 4)
        send_close(last_px + $urandom_range(0, 2000) - 1000);
      else if (mode < 6)
        send_close(last_px + px_step);
      else if (mode < 7)
        send_close(last_px);
      else begin
        px_step = $urandom_range(0, 50);
        send_close($urandom);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    gaps_on      = 1'b0;
    hold_results = 1'b0;
    last_px      = '0;
    px_step      = 32'd7;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of zero: single change, always zero deviation
    set_window(9'd0);
    send_close(32'h0000_0000);
    send_close(32'hFFFF_FFFF);
    send_close(32'h0000_0000);
    send_close(32'hFFFF_FFFF);
    send_close(32'h8000_0000);
    send_close(32'h7FFF_FFFF);

    // smallest real window: extremes, then equal changes for zero deviation
    set_window(9'd1);
    send_close(32'h0000_0000);
    send_close(32'hFFFF_FFFF);
    send_close(32'h0000_0001);
    send_close(32'hFFFF_FFFE);
    send_close(32'd100);
    send_close(32'd200);
    send_close(32'd300);
    send_close(32'd400);
    send_close(32'd400);
    send_close(32'd400);
    send_close(32'd5);
    send_close(32'hAAAA_AAAA);
    send_close(32'h5555_5555);

    // random gaps, with the long result stall at the start of the phase
    gaps_on      = 1'b1;
    hold_results = 1'b1;
    send_random(20);

    set_window(9'd2);
    send_random(20);
    set_window(9'd5);
    gaps_on = 1'b0;
    send_random(12);
    gaps_on = 1'b1;

    // large window: long fill before the first result
    set_window(9'd250);
    send_random(256);

    // shrink: count already past the new threshold
    set_window(9'($urandom_range(3, 40)));
    send_random(15);
    set_window(9'd1);
    send_random(20);

    in_tvalid <= 1'b0;
    while (ratios_pending != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (fail_count == 0)
      $display("rescaled_range_abs_returns test passed");
    else
      $display("rescaled_range_abs_returns test failed");
    $finish;
  end

endmodule
